// ===== rtl/rkm_pkg.sv =====
// Shared types, action and outcome codes and register indexes of the keyword matcher.
package rkm_pkg;

    localparam int KEY_COUNT = 2;
    localparam int KEY_WORDS = 2;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] OUT_MATCH    = 2'd0;
    localparam logic [1:0] OUT_SILENT   = 2'd1;
    localparam logic [1:0] OUT_NO_MATCH = 2'd2;

    localparam logic [2:0] REG_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_COUNT    = 3'd1;
    localparam logic [2:0] REG_LEN0     = 3'd2;
    localparam logic [2:0] REG_LEN1     = 3'd3;
    localparam logic [2:0] REG_KEY0_LOW = 3'd4;
    localparam logic [2:0] REG_KEY0_HI  = 3'd5;
    localparam logic [2:0] REG_KEY1_LOW = 3'd6;
    localparam logic [2:0] REG_KEY1_HI  = 3'd7;

    typedef logic [KEY_WORDS-1:0][63:0] rkm_key_t;

    typedef struct packed {
        logic [15:0]                timeout;
        logic [1:0]                 count;
        logic [KEY_COUNT-1:0][4:0]  len;
        rkm_key_t [KEY_COUNT-1:0]   key;
    } rkm_cfg_t;

endpackage

// ===== rtl/rkm_cfg_regs.sv =====
// Configuration register file of the keyword matcher.
module rkm_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    output rkm_pkg::rkm_cfg_t cfg
);
    import rkm_pkg::*;

    rkm_cfg_t cfg_reg;
    rkm_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:  cfg_next.timeout   = cfg_data[15:0];
                REG_COUNT:    cfg_next.count     = cfg_data[1:0];
                REG_LEN0:     cfg_next.len[0]    = cfg_data[4:0];
                REG_LEN1:     cfg_next.len[1]    = cfg_data[4:0];
                REG_KEY0_LOW: cfg_next.key[0][0] = cfg_data;
                REG_KEY0_HI:  cfg_next.key[0][1] = cfg_data;
                REG_KEY1_LOW: cfg_next.key[1][0] = cfg_data;
                REG_KEY1_HI:  cfg_next.key[1][1] = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout   <= 16'd2000;
            cfg_reg.count     <= 2'd2;
            cfg_reg.len[0]    <= 5'd2;
            cfg_reg.len[1]    <= 5'd1;
            // Keyword zero resets to the text "OK".
            cfg_reg.key[0][0] <= 64'd19279;
            cfg_reg.key[0][1] <= 64'd0;
            cfg_reg.key[1][0] <= 64'd0;
            cfg_reg.key[1][1] <= 64'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/rkm_lane.sv =====
// One keyword lane: progress register and compare against the expected byte.
module rkm_lane #(
    parameter int MAX_PATTERN_LEN = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              enable,
    input  logic [7:0]        rx_byte,
    input  rkm_pkg::rkm_key_t key,
    input  logic [4:0]        len,
    output logic              hit
);
    import rkm_pkg::*;

    localparam int PW = $clog2(MAX_PATTERN_LEN);

    logic [PW-1:0] progress_reg;
    logic [PW-1:0] progress_next;
    logic [7:0]    pos;
    logic [7:0]    pos_inc;
    logic [7:0]    eff_len;
    logic [7:0]    expected;
    logic          same;

    always_comb
    begin
        pos     = 8'(progress_reg);
        pos_inc = pos + 8'd1;
        // Positions beyond the two key words read as a zero byte.
        if (pos < 8'd16)
            expected = key[pos[3]][{pos[2:0], 3'b000} +: 8];
        else
            expected = 8'd0;
        if (len == 5'd0)
            eff_len = 8'd1;
        else if (8'(len) > 8'(MAX_PATTERN_LEN))
            eff_len = 8'(MAX_PATTERN_LEN);
        else
            eff_len = 8'(len);
        same = (rx_byte == expected);
        hit  = same && (pos_inc >= eff_len);

        progress_next = progress_reg;
        if (clear)
            progress_next = '0;
        else if (enable)
            progress_next = same ? PW'(pos_inc) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            progress_reg <= '0;
        else
            progress_reg <= progress_next;
    end

endmodule

// ===== rtl/response_keyword_matcher.sv =====
// Top level of the keyword matcher: input register, listen control and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------
//   in      | into      | in_valid / in_stall    | action, rx_byte
//   out     | out of    | out_valid / out_stall  | outcome, pattern_index
//   cfg     | into      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item is taken every cycle while in_stall is low; its result, if any, passes from the
// input register to the result register. The compare of each keyword lane and the timeout
// compare sit between them, so one item is finished per cycle unless the result is stalled.
// Reset clears the listen state, the progress of each keyword and the registers to defaults.
// A stalled result holds the item behind it in the input register; in_stall rises only then.
module response_keyword_matcher #(
    parameter int NUM_PATTERNS    = 2,
    parameter int MAX_PATTERN_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  outcome,
    output logic        pattern_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import rkm_pkg::*;

    localparam int LANES = (NUM_PATTERNS < KEY_COUNT) ? NUM_PATTERNS : KEY_COUNT;

    rkm_cfg_t cfg;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] action_reg;
    logic [7:0] rx_byte_reg;

    logic        listening_reg;
    logic        listening_next;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic        byte_seen_reg;
    logic        byte_seen_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [1:0] outcome_reg;
    logic [1:0] outcome_next;
    logic       index_reg;
    logic       index_next;

    logic             accept;
    logic             process;
    logic             is_start;
    logic             is_byte;
    logic             is_tick;
    logic [1:0]       eff_count;
    logic [15:0]      elapsed_sat;
    logic             timed_out;
    logic [LANES-1:0] lane_active;
    logic [LANES-1:0] lane_en;
    logic [LANES-1:0] lane_hit;
    logic [LANES-1:0] lane_done;
    logic             any_done;
    logic             winner;
    logic             earlier_done;

    rkm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign process  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;
    assign accept   = in_valid && !in_stall;

    assign is_start = process && (action_reg == ACT_START);
    assign is_byte  = process && listening_reg && (action_reg == ACT_BYTE);
    assign is_tick  = process && listening_reg && (action_reg == ACT_TICK);

    always_comb
    begin
        if (cfg.count == 2'd0)
            eff_count = 2'd1;
        else if (cfg.count > 2'd2)
            eff_count = 2'd2;
        else
            eff_count = cfg.count;
    end

    for (genvar p = 0; p < LANES; p++)
    begin : g_lane
        assign lane_active[p] = (2'(p) < eff_count);

        rkm_lane #(
            .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (is_start),
            .enable  (lane_en[p]),
            .rx_byte (rx_byte_reg),
            .key     (cfg.key[p]),
            .len     (cfg.len[p]),
            .hit     (lane_hit[p])
        );
    end

    // A completed lane stops the later lanes from being examined on the same byte.
    always_comb
    begin
        earlier_done = 1'b0;
        for (int p = 0; p < LANES; p++)
        begin
            lane_en[p]   = is_byte && lane_active[p] && !earlier_done;
            lane_done[p] = lane_en[p] && lane_hit[p];
            earlier_done = earlier_done || lane_done[p];
        end
        any_done = earlier_done;
        winner   = 1'b0;
        for (int p = LANES - 1; p >= 0; p--)
        begin
            if (lane_done[p])
                winner = 1'(p);
        end
    end

    always_comb
    begin
        elapsed_sat = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
        timed_out   = (elapsed_sat >= cfg.timeout);

        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;

        listening_next = listening_reg;
        elapsed_next   = elapsed_reg;
        byte_seen_next = byte_seen_reg;
        if (is_start)
        begin
            listening_next = 1'b1;
            elapsed_next   = 16'd0;
            byte_seen_next = 1'b0;
        end
        else if (is_byte)
        begin
            byte_seen_next = 1'b1;
            if (any_done)
                listening_next = 1'b0;
        end
        else if (is_tick)
        begin
            elapsed_next = elapsed_sat;
            if (timed_out)
                listening_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        outcome_next   = outcome_reg;
        index_next     = index_reg;
        if (is_byte && any_done)
        begin
            out_valid_next = 1'b1;
            outcome_next   = OUT_MATCH;
            index_next     = winner;
        end
        else if (is_tick && timed_out)
        begin
            out_valid_next = 1'b1;
            outcome_next   = byte_seen_reg ? OUT_NO_MATCH : OUT_SILENT;
            index_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            listening_reg <= 1'b0;
            elapsed_reg   <= 16'd0;
            byte_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            listening_reg <= listening_next;
            elapsed_reg   <= elapsed_next;
            byte_seen_reg <= byte_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= action;
            rx_byte_reg <= rx_byte;
        end
        outcome_reg <= outcome_next;
        index_reg   <= index_next;
    end

    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_reg;
    assign pattern_index = index_reg;

endmodule

// ===== rtl/rkm_checker.sv =====
// Port-level checks of the keyword matcher and the bind that attaches them.
module rkm_port_checks (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] outcome,
    input logic       pattern_index
);
    import rkm_pkg::*;

    // Input back-pressure comes only from a result that is waiting.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome == OUT_MATCH || outcome == OUT_SILENT
                       || outcome == OUT_NO_MATCH))
        else $error("result carries an unused outcome code");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome != OUT_MATCH) |-> (pattern_index == 1'b0))
        else $error("keyword index set on a timeout result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(outcome)
                                      && $stable(pattern_index)))
        else $error("stalled result changed");

endmodule

bind response_keyword_matcher rkm_port_checks u_rkm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .outcome       (outcome),
    .pattern_index (pattern_index)
);
